// ----- hw/rtl/htsd_pkg.sv -----
package htsd_pkg;

  // Field widths of the stream and of the node table.
  localparam int SYM_W       = 8;
  localparam int IDX_W       = 9;
  localparam int ENTRY_W     = 2 * IDX_W + 1;
  localparam int LEAF_BIT    = ENTRY_W - 1;
  localparam int KIND_W      = 2;
  localparam int BIT_IDX_W   = 3;
  localparam int LEAF_CNT_W  = 4;
  localparam int STACK_DEPTH = 256;
  localparam int STK_AW      = 8;

  // Default number of node table slots.
  localparam int NODE_SLOTS_DEF = 511;

  // Configuration port.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int PAD_W  = 3;
  localparam logic REG_PADDING = 1'b0;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // One result handed from the core to the output stage.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [KIND_W-1:0] kind;
    logic              run_end;
  } res_t;

endpackage

// ----- hw/rtl/htsd_apb.sv -----
module htsd_apb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htsd_pkg::CFG_AW-1:0]   paddr,
  input  logic [htsd_pkg::CFG_DW-1:0]   pwdata,
  output logic [htsd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic [htsd_pkg::PAD_W-1:0]    padding
);

  logic [htsd_pkg::PAD_W-1:0] pad_r;
  logic                       reg_idx;
  logic                       wr_en;

  // Registers sit on 4-byte steps; bit 2 picks the register.
  assign reg_idx = paddr[htsd_pkg::CFG_AW-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == htsd_pkg::REG_PADDING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r <= '0;
    end else if (wr_en) begin
      pad_r <= pwdata[htsd_pkg::PAD_W-1:0];
    end
  end

  // Read back the padding register; unused addresses read zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == htsd_pkg::REG_PADDING) begin
      prdata = htsd_pkg::CFG_DW'(pad_r);
    end
  end

  assign padding = pad_r;

endmodule

// ----- hw/rtl/htsd_core.sv -----
module htsd_core #(
  parameter int NODE_SLOTS = htsd_pkg::NODE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [htsd_pkg::SYM_W-1:0]  in_byte,
  input  logic                        in_final,
  input  logic [htsd_pkg::PAD_W-1:0]  padding,
  output logic                        res_valid,
  input  logic                        res_ready,
  output htsd_pkg::res_t              res
);

  localparam int ADDR_W = $clog2(NODE_SLOTS);
  localparam int IW     = htsd_pkg::IDX_W;
  localparam int EW     = htsd_pkg::ENTRY_W;
  localparam int SW     = htsd_pkg::SYM_W;
  localparam logic [IW-1:0] SLOTS_V = IW'(NODE_SLOTS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIT   = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_MAKE  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Stream phases.
  localparam logic [1:0] PH_LOAD   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  // Control state.
  logic [2:0]                           st_r, st_nxt;
  logic [1:0]                           phase_r, phase_nxt;
  logic [IW-1:0]                        node_cnt_r, node_cnt_nxt;
  logic [IW-1:0]                        stk_lvl_r, stk_lvl_nxt;
  logic [htsd_pkg::LEAF_CNT_W-1:0]      leaf_left_r, leaf_left_nxt;
  logic [SW-1:0]                        leaf_sh_r, leaf_sh_nxt;
  logic                                 prev_leaf_r, prev_leaf_nxt;
  logic                                 use_root_r, use_root_nxt;
  logic                                 pend_valid_r, pend_valid_nxt;

  // Payload state.
  logic [SW-1:0]                        byte_r, byte_nxt;
  logic                                 fin_r, fin_nxt;
  logic [htsd_pkg::BIT_IDX_W-1:0]       lowest_r, lowest_nxt;
  logic [htsd_pkg::BIT_IDX_W-1:0]       bidx_r, bidx_nxt;
  logic [EW-1:0]                        root_r;
  logic [SW-1:0]                        pend_sym_r, pend_sym_nxt;
  logic [htsd_pkg::KIND_W-1:0]          pend_kind_r, pend_kind_nxt;

  // Memories and their ports.
  logic [EW-1:0]                        node_mem [NODE_SLOTS];
  logic [EW-1:0]                        node_rd_r;
  logic [IW-1:0]                        stk_mem [htsd_pkg::STACK_DEPTH];
  logic [IW-1:0]                        stk_rd_r;
  logic                                 node_we, node_re, stk_we, stk_re;
  logic [IW-1:0]                        node_wa, node_ra;
  logic [EW-1:0]                        node_wd;
  logic [htsd_pkg::STK_AW-1:0]          stk_wa, stk_ra;
  logic [IW-1:0]                        stk_wd;

  // Step signals.
  logic                                 bit_v, last_bit, do_make, adv, err, go;
  logic                                 new_res;
  logic [SW-1:0]                        new_sym;
  logic [htsd_pkg::KIND_W-1:0]          new_kind;
  logic [IW-1:0]                        n_plus, idx_last, child, p_plus;
  logic [EW-1:0]                        cur_e;
  logic [SW-1:0]                        sh_new;

  function automatic logic [EW-1:0] leaf_entry(input logic [SW-1:0] sym);
    leaf_entry = {1'b1, {(EW-1-SW){1'b0}}, sym};
  endfunction

  function automatic logic [EW-1:0] inner_entry(input logic [IW-1:0] left,
                                                input logic [IW-1:0] right);
    inner_entry = {1'b0, left, right};
  endfunction

  // Top of stack address below the given level.
  function automatic logic [htsd_pkg::STK_AW-1:0] idx_last_stk(input logic [IW-1:0] lvl);
    logic [IW-1:0] dec;
    dec          = lvl - 1'b1;
    idx_last_stk = dec[htsd_pkg::STK_AW-1:0];
  endfunction

  always_comb begin
    st_nxt         = st_r;
    phase_nxt      = phase_r;
    node_cnt_nxt   = node_cnt_r;
    stk_lvl_nxt    = stk_lvl_r;
    leaf_left_nxt  = leaf_left_r;
    leaf_sh_nxt    = leaf_sh_r;
    prev_leaf_nxt  = prev_leaf_r;
    use_root_nxt   = use_root_r;
    pend_valid_nxt = pend_valid_r;
    byte_nxt       = byte_r;
    fin_nxt        = fin_r;
    lowest_nxt     = lowest_r;
    bidx_nxt       = bidx_r;
    pend_sym_nxt   = pend_sym_r;
    pend_kind_nxt  = pend_kind_r;
    node_we        = 1'b0;
    node_re        = 1'b0;
    node_wa        = node_cnt_r;
    node_ra        = '0;
    node_wd        = '0;
    stk_we         = 1'b0;
    stk_re         = 1'b0;
    stk_wa         = stk_lvl_r[htsd_pkg::STK_AW-1:0];
    stk_ra         = stk_wa;
    stk_wd         = node_cnt_r;
    in_ready       = 1'b0;
    do_make        = 1'b0;
    adv            = 1'b0;
    err            = 1'b0;
    new_res        = 1'b0;
    new_sym        = '0;
    new_kind       = htsd_pkg::KIND_SYMBOL;

    bit_v    = byte_r[bidx_r];
    last_bit = (bidx_r == lowest_r);
    n_plus   = node_cnt_r + 1'b1;
    idx_last = node_cnt_r - 1'b1;
    p_plus   = stk_rd_r + 1'b1;
    cur_e    = use_root_r ? root_r : node_rd_r;
    child    = bit_v ? cur_e[IW-1:0] : cur_e[2*IW-1:IW];
    sh_new   = {leaf_sh_r[SW-2:0], bit_v};

    case (st_r)
      // Wait for the next byte; a halted stream swallows bytes here.
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          byte_nxt   = in_byte;
          fin_nxt    = in_final;
          lowest_nxt = in_final ? padding : '0;
          bidx_nxt   = htsd_pkg::BIT_IDX_W'(SW - 1);
          if (phase_r != PH_HALT) begin
            st_nxt = S_BIT;
          end
        end
      end

      // One bit of the tree header or of the coded data.
      S_BIT: begin
        if (phase_r == PH_LOAD) begin
          if (leaf_left_r != '0) begin
            // Shift in a symbol bit of the current leaf.
            leaf_sh_nxt   = sh_new;
            leaf_left_nxt = leaf_left_r - 1'b1;
            adv           = 1'b1;
            if (leaf_left_r == htsd_pkg::LEAF_CNT_W'(1)) begin
              if (stk_lvl_r == '0 && idx_last == '0) begin
                err = 1'b1;
              end else begin
                node_we = 1'b1;
                node_wa = idx_last;
                node_wd = leaf_entry(sh_new);
                if (stk_lvl_r == '0) begin
                  phase_nxt    = PH_DECODE;
                  use_root_nxt = 1'b1;
                end
              end
            end
          end else if (node_cnt_r >= SLOTS_V) begin
            err = 1'b1;
          end else if (prev_leaf_r) begin
            // A leaf closed a left subtree: its parent's right child comes next.
            if (stk_lvl_r == '0) begin
              err = 1'b1;
            end else begin
              stk_re = 1'b1;
              stk_ra = idx_last_stk(stk_lvl_r);
              st_nxt = S_POP;
            end
          end else begin
            do_make = 1'b1;
          end
        end else begin
          // Step one node down the tree.
          if (cur_e[htsd_pkg::LEAF_BIT] || child >= SLOTS_V) begin
            err = 1'b1;
          end else begin
            node_re = 1'b1;
            node_ra = child;
            st_nxt  = S_FETCH;
          end
        end
      end

      // Popped parent gets the new node as its right child.
      S_POP: begin
        node_we     = 1'b1;
        node_wa     = stk_rd_r;
        node_wd     = inner_entry(p_plus, node_cnt_r);
        stk_lvl_nxt = stk_lvl_r - 1'b1;
        st_nxt      = S_MAKE;
      end

      S_MAKE: begin
        do_make = 1'b1;
      end

      // Child entry is back from the table.
      S_FETCH: begin
        adv = 1'b1;
        if (node_rd_r[htsd_pkg::LEAF_BIT]) begin
          new_res      = 1'b1;
          new_sym      = node_rd_r[SW-1:0];
          use_root_nxt = 1'b1;
        end else begin
          use_root_nxt = 1'b0;
        end
      end

      // The final byte closes the stream.
      S_END: begin
        st_nxt = S_DONE;
        if (fin_r && phase_r != PH_HALT) begin
          new_res   = 1'b1;
          new_kind  = (phase_r == PH_LOAD) ? htsd_pkg::KIND_ERROR : htsd_pkg::KIND_END;
          phase_nxt = PH_HALT;
        end
      end

      // Hand over the held result as the last one of this byte.
      S_DONE: begin
        pend_valid_nxt = 1'b0;
        st_nxt         = S_IDLE;
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // Create the next tree node: a leaf, or an internal node that is pushed.
    if (do_make) begin
      if (bit_v) begin
        node_we       = 1'b1;
        node_wa       = node_cnt_r;
        node_wd       = leaf_entry('0);
        node_cnt_nxt  = n_plus;
        leaf_left_nxt = htsd_pkg::LEAF_CNT_W'(SW);
        leaf_sh_nxt   = '0;
        prev_leaf_nxt = 1'b1;
        adv           = 1'b1;
      end else if (stk_lvl_r[IW-1]) begin
        err = 1'b1;
      end else begin
        stk_we        = 1'b1;
        stk_wa        = stk_lvl_r[htsd_pkg::STK_AW-1:0];
        stk_wd        = node_cnt_r;
        stk_lvl_nxt   = stk_lvl_r + 1'b1;
        node_we       = 1'b1;
        node_wa       = node_cnt_r;
        node_wd       = inner_entry(n_plus, '0);
        node_cnt_nxt  = n_plus;
        prev_leaf_nxt = 1'b0;
        adv           = 1'b1;
      end
    end

    // Move to the next bit, or to the end of the byte.
    if (adv) begin
      if (last_bit) begin
        st_nxt = S_END;
      end else begin
        bidx_nxt = bidx_r - 1'b1;
        st_nxt   = S_BIT;
      end
    end

    // A malformed tree ends the stream; the rest of the byte is dropped.
    if (err) begin
      new_res   = 1'b1;
      new_kind  = htsd_pkg::KIND_ERROR;
      new_sym   = '0;
      phase_nxt = PH_HALT;
      st_nxt    = S_DONE;
      node_we   = 1'b0;
      stk_we    = 1'b0;
      stk_re    = 1'b0;
      node_re   = 1'b0;
    end

    // A new result pushes the held one out; the step waits for room.
    if (new_res) begin
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = new_sym;
      pend_kind_nxt  = new_kind;
    end

    if (st_r == S_DONE) begin
      go = !pend_valid_r || res_ready;
    end else begin
      go = !(new_res && pend_valid_r) || res_ready;
    end

    res_valid   = pend_valid_r && (new_res || st_r == S_DONE);
    res.sym     = pend_sym_r;
    res.kind    = pend_kind_r;
    res.run_end = (st_r == S_DONE);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      phase_r      <= PH_LOAD;
      node_cnt_r   <= '0;
      stk_lvl_r    <= '0;
      leaf_left_r  <= '0;
      leaf_sh_r    <= '0;
      prev_leaf_r  <= 1'b0;
      use_root_r   <= 1'b1;
      pend_valid_r <= 1'b0;
    end else if (go) begin
      st_r         <= st_nxt;
      phase_r      <= phase_nxt;
      node_cnt_r   <= node_cnt_nxt;
      stk_lvl_r    <= stk_lvl_nxt;
      leaf_left_r  <= leaf_left_nxt;
      leaf_sh_r    <= leaf_sh_nxt;
      prev_leaf_r  <= prev_leaf_nxt;
      use_root_r   <= use_root_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (go) begin
      byte_r      <= byte_nxt;
      fin_r       <= fin_nxt;
      lowest_r    <= lowest_nxt;
      bidx_r      <= bidx_nxt;
      pend_sym_r  <= pend_sym_nxt;
      pend_kind_r <= pend_kind_nxt;
      if (node_we && node_wa == '0) begin
        root_r <= node_wd;
      end
    end
  end

  // Node table: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (go && node_we) begin
      node_mem[node_wa[ADDR_W-1:0]] <= node_wd;
    end
    if (go && node_re) begin
      node_rd_r <= node_mem[node_ra[ADDR_W-1:0]];
    end
  end

  // Stack of internal nodes waiting for their right child.
  always_ff @(posedge clk) begin
    if (go && stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (go && stk_re) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

endmodule

// ----- hw/rtl/huffman_tree_stream_decoder.sv -----
// The core takes one byte at a time, in S_IDLE. Each tree-header bit is then handled in S_BIT,
// passing on through S_POP and S_MAKE when a right child is linked; each coded bit goes through
// S_BIT (node-table read), then S_FETCH (check); S_END and then S_DONE close the byte. A result
// waiting on a full output register stalls the core. Reset (rst_n, synchronous, active low)
// returns to tree loading with empty table and stack, a cleared padding register and an empty
// output register.
module huffman_tree_stream_decoder #(
  parameter int NODE_SLOTS = htsd_pkg::NODE_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] code_byte
  input  logic                                in_tlast,   // final_byte
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] symbol
  output logic [htsd_pkg::KIND_W-1:0]         out_tuser,  // [1:0] kind
  output logic                                out_tlast,  // run_end
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [htsd_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [htsd_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [htsd_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  logic [htsd_pkg::PAD_W-1:0] padding;
  logic                       res_valid, res_ready;
  htsd_pkg::res_t             res;

  logic                       out_valid_r;
  htsd_pkg::res_t             out_r;

  htsd_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .padding (padding)
  );

  htsd_core #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_final  (in_tlast),
    .padding   (padding),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.sym;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.run_end;

  // An end or error result always closes the beats of its byte.
  a_stop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != htsd_pkg::KIND_SYMBOL) |-> (out_tlast && out_tdata == '0))
    else $error("end or error result not marked as last of its byte");

  // Right after an end or error result is taken, no further result is offered.
  a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser != htsd_pkg::KIND_SYMBOL) |=> !out_tvalid)
    else $error("result produced after end of stream");

  // The core never offers a result while waiting for a new byte with nothing held.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && !res_valid) |=> !(res_valid && $past(in_tready) && !$past(in_tvalid)))
    else $error("result appeared without an accepted byte");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import htsd_pkg::*;

  // Return codes of one step of the tree walk.
  localparam int WALK_ERROR = -1;
  localparam int NO_SYMBOL  = 256;
  localparam logic [CFG_AW-1:0] PAD_ADDR = CFG_AW'(4 * int'(REG_PADDING));
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;

  // Tracks the decoder state, predicts the results of each byte and checks them.
  class decode_scoreboard;
    typedef enum logic [1:0] {TREE_LOAD, DECODING, HALTED} walk_phase_t;

    walk_phase_t phase;
    logic [ENTRY_W-1:0] nodes [NODE_SLOTS_DEF];
    logic [IDX_W-1:0] pending [STACK_DEPTH];
    int unsigned node_count;
    int unsigned stack_level;
    int unsigned leaf_bits_left;
    int unsigned walk_node;
    logic [SYM_W-1:0] leaf_shift;
    logic [PAD_W-1:0] padding;
    res_t expected_results [$];
    int mismatches;

    function new();
      phase = TREE_LOAD;
      foreach (nodes[i]) nodes[i] = '0;
      foreach (pending[i]) pending[i] = '0;
      node_count = 0;
      stack_level = 0;
      leaf_bits_left = 0;
      walk_node = 0;
      leaf_shift = '0;
      padding = '0;
      mismatches = 0;
    endfunction

    function res_t result_of(logic [SYM_W-1:0] sym, logic [KIND_W-1:0] kind);
      res_t r;
      r.sym = sym;
      r.kind = kind;
      r.run_end = 1'b0;
      return r;
    endfunction

    // One header bit. Returns 1 when the tree is malformed.
    function bit load_bit(bit b);
      int unsigned n;
      int unsigned idx;
      int unsigned p;
      if (leaf_bits_left > 0) begin
        leaf_shift = {leaf_shift[SYM_W-2:0], b};
        leaf_bits_left--;
        if (leaf_bits_left != 0) return 1'b0;
        if (node_count == 0 || node_count > NODE_SLOTS_DEF) return 1'b1;
        idx = node_count - 1;
        nodes[idx] = '0;
        nodes[idx][LEAF_BIT] = 1'b1;
        nodes[idx][SYM_W-1:0] = leaf_shift;
        // The last leaf with nothing pending closes the tree.
        if (stack_level == 0) begin
          if (idx == 0) return 1'b1;
          phase = DECODING;
          walk_node = 0;
        end
        return 1'b0;
      end
      n = node_count;
      if (n >= NODE_SLOTS_DEF) return 1'b1;
      // A node that follows a leaf is the right child of the newest pending node.
      if (n > 0 && nodes[n-1][LEAF_BIT]) begin
        if (stack_level == 0) return 1'b1;
        stack_level--;
        p = pending[stack_level % STACK_DEPTH];
        if (p >= NODE_SLOTS_DEF) return 1'b1;
        nodes[p][IDX_W-1:0] = IDX_W'(n);
      end
      node_count = n + 1;
      if (b) begin
        nodes[n] = '0;
        nodes[n][LEAF_BIT] = 1'b1;
        leaf_bits_left = SYM_W;
        leaf_shift = '0;
      end else begin
        if (stack_level >= STACK_DEPTH) return 1'b1;
        pending[stack_level] = IDX_W'(n);
        stack_level++;
        nodes[n] = '0;
        nodes[n][2*IDX_W-1:IDX_W] = IDX_W'(n + 1);
      end
      return 1'b0;
    endfunction

    // One coded bit: a symbol, NO_SYMBOL, or WALK_ERROR.
    function int decode_bit(bit b);
      logic [ENTRY_W-1:0] e;
      logic [ENTRY_W-1:0] ce;
      int unsigned child;
      if (walk_node >= NODE_SLOTS_DEF) return WALK_ERROR;
      e = nodes[walk_node];
      if (e[LEAF_BIT]) return WALK_ERROR;
      child = b ? e[IDX_W-1:0] : e[2*IDX_W-1:IDX_W];
      if (child >= NODE_SLOTS_DEF) return WALK_ERROR;
      ce = nodes[child];
      if (ce[LEAF_BIT]) begin
        walk_node = 0;
        return int'(ce[SYM_W-1:0]);
      end
      walk_node = child;
      return NO_SYMBOL;
    endfunction

    // Notes an accepted beat and queues the results it causes.
    function void note_byte(logic [7:0] code, bit fin);
      res_t burst [$];
      res_t r;
      int lowest;
      int got;
      if (phase == HALTED) return;
      lowest = fin ? int'(padding) : 0;
      for (int i = 7; i >= lowest; i--) begin
        if (phase == TREE_LOAD) begin
          if (load_bit(code[i])) begin
            burst.push_back(result_of('0, KIND_ERROR));
            phase = HALTED;
            break;
          end
        end else if (phase == DECODING) begin
          got = decode_bit(code[i]);
          if (got == WALK_ERROR) begin
            burst.push_back(result_of('0, KIND_ERROR));
            phase = HALTED;
            break;
          end
          if (got != NO_SYMBOL) burst.push_back(result_of(got[SYM_W-1:0], KIND_SYMBOL));
        end
      end
      // The last byte ends the stream, or reports a tree left unfinished.
      if (fin && phase != HALTED) begin
        burst.push_back(result_of('0, (phase == TREE_LOAD) ? KIND_ERROR : KIND_END));
        phase = HALTED;
      end
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.run_end = 1'b1;
        burst.push_back(r);
      end
      foreach (burst[i]) expected_results.push_back(burst[i]);
    endfunction

    // Compares a result beat with the oldest expected result.
    function void check_result(res_t seen);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: symbol %0d, kind %0d, run_end %0d",
               seen.sym, seen.kind, seen.run_end);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (seen.sym !== want.sym) begin
        $error("symbol: expected %0d, got %0d", want.sym, seen.sym);
        mismatches++;
      end
      if (seen.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, seen.kind);
        mismatches++;
      end
      if (seen.run_end !== want.run_end) begin
        $error("run_end: expected %0d, got %0d", want.run_end, seen.run_end);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  decode_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  res_t seen_beat;

  huffman_tree_stream_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result side: checks each beat and stalls at random, or for one long stretch.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_beat.sym = out_tdata;
      seen_beat.kind = out_tuser;
      seen_beat.run_end = out_tlast;
      sb.check_result(seen_beat);
    end
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One register access: a setup phase, then an access phase that waits for cfg_pready.
  task automatic cfg_access(input bit wr, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= PAD_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Writes the padding register, then reads it back.
  task automatic write_padding(input logic [PAD_W-1:0] value);
    logic [CFG_DW-1:0] rdata;
    cfg_access(1'b1, CFG_DW'(value), rdata);
    sb.padding = value;
    @(posedge clk);
    cfg_access(1'b0, '0, rdata);
    if (rdata !== CFG_DW'(value)) begin
      $error("padding_count: expected %0d, got %0d", value, rdata);
      sb.mismatches++;
    end
    @(posedge clk);
  endtask

  // Offers one byte after a random idle time and waits for the handshake.
  task automatic send_byte(input logic [7:0] code, input bit fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= code;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(code, fin);
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit stream_bits [$];
    logic [7:0] stream_bytes [$];
    logic [7:0] opening [4];
    logic [7:0] sym;
    logic [7:0] b;
    logic [PAD_W-1:0] last_pad;
    int n_internal;
    int p_internal;
    int open_slots;
    int leaf_no;
    int target;
    int bounds [4];

    sb = new();
    opening = '{8'h00, 8'hFF, 8'hA5, 8'h5A};

    // Random full tree in preorder; now and then a full table of 256 leaves.
    n_internal = ($urandom_range(7) == 0) ? 255 : $urandom_range(1, 40);
    p_internal = $urandom_range(10, 90);
    open_slots = 1;
    leaf_no = 0;
    while (open_slots > 0) begin
      if (n_internal > 0 && (open_slots == 1 || $urandom_range(99) < p_internal)) begin
        stream_bits.push_back(1'b0);
        n_internal--;
        open_slots++;
      end else begin
        stream_bits.push_back(1'b1);
        sym = (leaf_no == 0) ? 8'h00 : (leaf_no == 1) ? 8'hFF : 8'($urandom);
        for (int k = 7; k >= 0; k--) stream_bits.push_back(sym[k]);
        leaf_no++;
        open_slots--;
      end
    end

    // Coded data: a few fixed patterns first, then random bits.
    foreach (opening[i]) begin
      for (int k = 7; k >= 0; k--) stream_bits.push_back(opening[i][k]);
    end
    target = 425;
    if (stream_bits.size() / 8 + 60 > target) target = stream_bits.size() / 8 + 60;
    while (stream_bits.size() < 8 * target) stream_bits.push_back(1'($urandom_range(1)));
    for (int i = 0; i < target; i++) begin
      b = '0;
      for (int j = 0; j < 8; j++) b = {b[6:0], stream_bits[8*i+j]};
      stream_bytes.push_back(b);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_padding(3'd7);

    bounds = '{0, target * 4 / 10, target * 7 / 10, target};
    case ($urandom_range(2))
      0: last_pad = '0;
      1: last_pad = 3'd7;
      default: last_pad = PAD_W'($urandom_range(7));
    endcase

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 8;
          wait_drained();
          write_padding('0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          wait_drained();
          write_padding(last_pad);
        end
      endcase
      for (int i = bounds[ph]; i < bounds[ph+1]; i++) begin
        // Long result stall while bytes keep coming, so the input backs up.
        if (ph == 2 && i == bounds[ph] + 20) hold_armed = 1'b1;
        send_byte(stream_bytes[i], i == target - 1);
      end
      // A few bytes after the stream has ended must give nothing.
      if (ph == 2) begin
        repeat (3) send_byte(8'($urandom), 1'($urandom_range(1)));
      end
      in_tvalid <= 1'b0;
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/htsd_pkg.sv
hw/rtl/htsd_apb.sv
hw/rtl/htsd_core.sv
hw/rtl/huffman_tree_stream_decoder.sv
sim/testbench.sv
